>>> hw/rtl/clt_pkg.sv
`timescale 1ns / 1ps

package clt_pkg;

	localparam int POS_W     = 6;
	localparam int VAL_W     = 32;
	localparam int CNT_W     = 7;
	localparam int MAX_ITM_W = 64;

	typedef logic [2:0]       action_t;
	typedef logic [1:0]       status_t;
	typedef logic [POS_W-1:0] pos_t;
	typedef logic [VAL_W-1:0] word_t;
	typedef logic [CNT_W-1:0] ecount_t;

	localparam action_t ACT_APPEND     = 3'd0;
	localparam action_t ACT_GET        = 3'd1;
	localparam action_t ACT_REMOVE_AT  = 3'd2;
	localparam action_t ACT_CONTAINS   = 3'd3;
	localparam action_t ACT_REMOVE_VAL = 3'd4;
	localparam action_t ACT_CLEAR      = 3'd5;

	localparam status_t ST_OK      = 2'd0;
	localparam status_t ST_FULL    = 2'd1;
	localparam status_t ST_RANGE   = 2'd2;
	localparam status_t ST_MISSING = 2'd3;

	typedef logic [1:0] ptr_op_t;
	localparam ptr_op_t PTR_HOLD = 2'd0;
	localparam ptr_op_t PTR_POS  = 2'd1;
	localparam ptr_op_t PTR_ZERO = 2'd2;
	localparam ptr_op_t PTR_INC  = 2'd3;

	typedef logic [1:0] cnt_op_t;
	localparam cnt_op_t CNT_HOLD  = 2'd0;
	localparam cnt_op_t CNT_INC   = 2'd1;
	localparam cnt_op_t CNT_DEC   = 2'd2;
	localparam cnt_op_t CNT_CLEAR = 2'd3;

	typedef logic [2:0] rsel_t;
	localparam rsel_t RA_POS  = 3'd0;
	localparam rsel_t RA_POS1 = 3'd1;
	localparam rsel_t RA_ZERO = 3'd2;
	localparam rsel_t RA_PTR1 = 3'd3;
	localparam rsel_t RA_PTR2 = 3'd4;

	typedef struct packed {
		logic    req_load;
		logic    mem_we;
		logic    wr_shift;
		logic    mem_re;
		rsel_t   rsel;
		ptr_op_t ptr_op;
		cnt_op_t cnt_op;
		logic    st_load;
		status_t st_code;
		logic    out_load;
	} clt_cmd_t;

	typedef struct packed {
		action_t act;
		logic    full;
		logic    pos_ok;
		logic    count_zero;
		logic    hit;
		logic    ptr_next_ok;
		logic    can_load;
	} clt_stat_t;

endpackage

>>> hw/rtl/clt_req_if.sv
`timescale 1ns / 1ps

interface clt_req_if;
	import clt_pkg::*;

	logic    valid;
	logic    ready;
	action_t action;
	pos_t    position;
	word_t   entry_value;

	modport source(output valid, action, position, entry_value, input ready);
	modport sink(input valid, action, position, entry_value, output ready);
endinterface

>>> hw/rtl/clt_rsp_if.sv
`timescale 1ns / 1ps

interface clt_rsp_if;
	import clt_pkg::*;

	logic    valid;
	logic    ready;
	word_t   read_value;
	status_t status;
	ecount_t entry_count;

	modport source(output valid, read_value, status, entry_count, input ready);
	modport sink(input valid, read_value, status, entry_count, output ready);
endinterface

>>> hw/rtl/clt_ctrl.sv
`timescale 1ns / 1ps

module clt_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	input  clt_pkg::clt_stat_t stat,
	output clt_pkg::clt_cmd_t  cmd,
	output logic               idle
);
	import clt_pkg::*;

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_EXEC  = 3'd1;
	localparam logic [2:0] S_SCAN  = 3'd2;
	localparam logic [2:0] S_SHIFT = 3'd3;
	localparam logic [2:0] S_EMIT  = 3'd4;

	logic [2:0] state_q;
	logic [2:0] state_nxt;

	assign idle = (state_q == S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		cmd       = '0;
		state_nxt = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					cmd.req_load = 1'b1;
					state_nxt    = S_EXEC;
				end
			end
			S_EXEC: begin
				cmd.st_load = 1'b1;
				cmd.st_code = ST_OK;
				state_nxt   = S_EMIT;
				case (stat.act) inside
					ACT_APPEND: begin
						if (stat.full) begin
							cmd.st_code = ST_FULL;
						end else begin
							cmd.mem_we = 1'b1;
							cmd.cnt_op = CNT_INC;
						end
					end
					ACT_GET: begin
						if (stat.pos_ok) begin
							cmd.mem_re = 1'b1;
							cmd.rsel   = RA_POS;
						end else begin
							cmd.st_code = ST_RANGE;
						end
					end
					ACT_REMOVE_AT: begin
						if (stat.pos_ok) begin
							cmd.ptr_op = PTR_POS;
							cmd.mem_re = 1'b1;
							cmd.rsel   = RA_POS1;
							state_nxt  = S_SHIFT;
						end else begin
							cmd.st_code = ST_RANGE;
						end
					end
					ACT_CONTAINS, ACT_REMOVE_VAL: begin
						if (stat.count_zero) begin
							cmd.st_code = ST_MISSING;
						end else begin
							cmd.ptr_op = PTR_ZERO;
							cmd.mem_re = 1'b1;
							cmd.rsel   = RA_ZERO;
							state_nxt  = S_SCAN;
						end
					end
					ACT_CLEAR: begin
						cmd.cnt_op = CNT_CLEAR;
					end
					default: begin
					end
				endcase
			end
			S_SCAN: begin
				if (stat.hit) begin
					if (stat.act == ACT_REMOVE_VAL) begin
						cmd.mem_re = 1'b1;
						cmd.rsel   = RA_PTR1;
						state_nxt  = S_SHIFT;
					end else begin
						state_nxt = S_EMIT;
					end
				end else if (stat.ptr_next_ok) begin
					cmd.ptr_op = PTR_INC;
					cmd.mem_re = 1'b1;
					cmd.rsel   = RA_PTR1;
				end else begin
					cmd.st_load = 1'b1;
					cmd.st_code = ST_MISSING;
					state_nxt   = S_EMIT;
				end
			end
			S_SHIFT: begin
				if (stat.ptr_next_ok) begin
					cmd.mem_we   = 1'b1;
					cmd.wr_shift = 1'b1;
					cmd.ptr_op   = PTR_INC;
					cmd.mem_re   = 1'b1;
					cmd.rsel     = RA_PTR2;
				end else begin
					cmd.cnt_op = CNT_DEC;
					state_nxt  = S_EMIT;
				end
			end
			S_EMIT: begin
				if (stat.can_load) begin
					cmd.out_load = 1'b1;
					state_nxt    = S_IDLE;
				end
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

endmodule

>>> hw/rtl/clt_datapath.sv
`timescale 1ns / 1ps

module clt_datapath #(
	parameter int CAPACITY   = 64,
	parameter int ITEM_WIDTH = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  clt_pkg::clt_cmd_t  cmd,
	output clt_pkg::clt_stat_t stat,
	input  clt_pkg::action_t   req_action,
	input  clt_pkg::pos_t      req_position,
	input  clt_pkg::word_t     req_entry_value,
	output logic               rsp_valid,
	input  logic               rsp_ready,
	output clt_pkg::word_t     rsp_read_value,
	output clt_pkg::status_t   rsp_status,
	output clt_pkg::ecount_t   rsp_entry_count
);
	import clt_pkg::*;

	localparam int AW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int XW = (AW + 1 > CW) ? AW + 1 : CW;
	localparam int PW = (POS_W > CW) ? POS_W : CW;

	logic [ITEM_WIDTH-1:0] mem [CAPACITY];

	action_t               act_q;
	pos_t                  pos_q;
	logic [ITEM_WIDTH-1:0] val_q;
	logic [AW-1:0]         ptr_q;
	logic [CW-1:0]         count_q;
	status_t               st_q;
	logic [ITEM_WIDTH-1:0] rdata_q;

	logic                  rsp_valid_q;
	word_t                 rsp_value_q;
	status_t               rsp_status_q;
	ecount_t               rsp_count_q;

	logic [MAX_ITM_W-1:0]  in_wide;
	logic [MAX_ITM_W-1:0]  rd_wide;
	logic [POS_W:0]        pos_inc1;
	logic [AW:0]           ptr_inc1;
	logic [AW:0]           ptr_inc2;
	logic [AW-1:0]         raddr;
	logic [AW-1:0]         waddr;
	logic [ITEM_WIDTH-1:0] wdata;

	assign in_wide  = MAX_ITM_W'(req_entry_value);
	assign rd_wide  = MAX_ITM_W'(rdata_q);
	assign pos_inc1 = (POS_W + 1)'(pos_q) + (POS_W + 1)'(1);
	assign ptr_inc1 = (AW + 1)'(ptr_q) + (AW + 1)'(1);
	assign ptr_inc2 = (AW + 1)'(ptr_q) + (AW + 1)'(2);

	always_comb begin
		case (cmd.rsel)
			RA_POS:  raddr = AW'(pos_q);
			RA_POS1: raddr = AW'(pos_inc1);
			RA_ZERO: raddr = '0;
			RA_PTR1: raddr = AW'(ptr_inc1);
			RA_PTR2: raddr = AW'(ptr_inc2);
			default: raddr = '0;
		endcase
	end

	assign waddr = cmd.wr_shift ? ptr_q : AW'(count_q);
	assign wdata = cmd.wr_shift ? rdata_q : val_q;

	always_ff @(posedge clk) begin
		if (cmd.mem_we) begin
			mem[waddr] <= wdata;
		end
		if (cmd.mem_re) begin
			rdata_q <= mem[raddr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.req_load) begin
			act_q <= req_action;
			pos_q <= req_position;
			val_q <= in_wide[ITEM_WIDTH-1:0];
		end
		if (cmd.st_load) begin
			st_q <= cmd.st_code;
		end
		case (cmd.ptr_op)
			PTR_POS:  ptr_q <= AW'(pos_q);
			PTR_ZERO: ptr_q <= '0;
			PTR_INC:  ptr_q <= AW'(ptr_inc1);
			default:  ptr_q <= ptr_q;
		endcase
		if (cmd.out_load) begin
			rsp_value_q  <= (act_q == ACT_GET && st_q == ST_OK) ? rd_wide[VAL_W-1:0] : '0;
			rsp_status_q <= st_q;
			rsp_count_q  <= CNT_W'(count_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			case (cmd.cnt_op)
				CNT_INC:   count_q <= count_q + CW'(1);
				CNT_DEC:   count_q <= count_q - CW'(1);
				CNT_CLEAR: count_q <= '0;
				default:   count_q <= count_q;
			endcase
			if (cmd.out_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	assign stat.act         = act_q;
	assign stat.full        = (count_q == CW'(CAPACITY));
	assign stat.pos_ok      = (PW'(pos_q) < PW'(count_q));
	assign stat.count_zero  = (count_q == '0);
	assign stat.hit         = (rdata_q == val_q);
	assign stat.ptr_next_ok = (XW'(ptr_inc1) < XW'(count_q));
	assign stat.can_load    = !rsp_valid_q || rsp_ready;

	assign rsp_valid       = rsp_valid_q;
	assign rsp_read_value  = rsp_value_q;
	assign rsp_status      = rsp_status_q;
	assign rsp_entry_count = rsp_count_q;

endmodule

>>> hw/rtl/compacting_list_table.sv
// Steps: append, get, clear and out-of-range requests are decoded in EXEC and their
// result is registered from EMIT; contains scans one entry a cycle in SCAN before EMIT;
// remove closes the gap in SHIFT one entry a cycle, one read and one write per cycle.
// A new result is not registered while the previous result is still stalled.
// Throughput: one item at a time; the next item is taken once the result is registered.
// Reset: count cleared and no result pending; entry memory keeps its contents.
`timescale 1ns / 1ps

module compacting_list_table #(
	parameter int CAPACITY   = 64,
	parameter int ITEM_WIDTH = 32
) (
	input logic      clk,
	input logic      arst_n,
	clt_req_if.sink  req,
	clt_rsp_if.source rsp
);
	import clt_pkg::*;

	clt_cmd_t  cmd;
	clt_stat_t stat;
	logic      idle;

	assign req.ready = idle;

	clt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.stat      (stat),
		.cmd       (cmd),
		.idle      (idle)
	);

	clt_datapath #(
		.CAPACITY   (CAPACITY),
		.ITEM_WIDTH (ITEM_WIDTH)
	) u_datapath (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.stat            (stat),
		.req_action      (req.action),
		.req_position    (req.position),
		.req_entry_value (req.entry_value),
		.rsp_valid       (rsp.valid),
		.rsp_ready       (rsp.ready),
		.rsp_read_value  (rsp.read_value),
		.rsp_status      (rsp.status),
		.rsp_entry_count (rsp.entry_count)
	);

endmodule

>>> hw/rtl/clt_checker.sv
`timescale 1ns / 1ps

module clt_checker #(
	parameter int CAPACITY = 64
) (
	input logic             clk,
	input logic             arst_n,
	input logic             req_valid,
	input logic             req_ready,
	input logic             rsp_valid,
	input logic             rsp_ready,
	input clt_pkg::word_t   rsp_read_value,
	input clt_pkg::status_t rsp_status,
	input clt_pkg::ecount_t rsp_entry_count
);
	import clt_pkg::*;

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_read_value)
			&& $stable(rsp_status) && $stable(rsp_entry_count))
		else $error("result changed while stalled");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("item taken while another is in progress");

	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_status == ST_FULL |-> rsp_entry_count == CNT_W'(CAPACITY))
		else $error("full reported below capacity");

	a_value_ok: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_read_value != '0 |-> rsp_status == ST_OK)
		else $error("read value on a failed request");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (CAPACITY > 127) || (rsp_entry_count <= CNT_W'(CAPACITY)))
		else $error("entry count above capacity");

endmodule

bind compacting_list_table clt_checker #(
	.CAPACITY (CAPACITY)
) u_clt_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.req_valid       (req.valid),
	.req_ready       (req.ready),
	.rsp_valid       (rsp.valid),
	.rsp_ready       (rsp.ready),
	.rsp_read_value  (rsp.read_value),
	.rsp_status      (rsp.status),
	.rsp_entry_count (rsp.entry_count)
);
